// File: rtl/totc_pkg.sv
// Shared types, constants and the microprogram for the tick compare core.
// No dependencies; imported by totc_seq and tickless_os_tick_compare_core.
`timescale 1ns / 1ps

package totc_pkg;

  localparam int unsigned OUT_W   = 24;  // width of elapsed and compare output words
  localparam int unsigned TPO_W   = 16;  // ticks_per_os_tick register
  localparam int unsigned MAXI_W  = 23;  // max_idle_os_ticks register
  localparam int unsigned REQ_W   = 32;  // idle request field
  localparam int unsigned REM_W   = TPO_W + 1;
  localparam int unsigned PROD_W  = MAXI_W + TPO_W;
  localparam int unsigned CFG_W   = MAXI_W;
  localparam int unsigned PC_W    = 4;

  localparam logic [TPO_W-1:0]  TPO_RESET  = 16'd256;
  localparam logic [MAXI_W-1:0] MAXI_RESET = 23'd16384;

  // Configuration register indexes
  localparam logic CFG_TPO      = 1'b0;
  localparam logic CFG_MAX_IDLE = 1'b1;

  typedef enum logic [3:0] {
    OP_WAIT,       // take an input word
    OP_NOP,
    OP_LOAD_DIFF,  // |counter - mark| into the divider, keep sign
    OP_DIV_STEP,   // one restoring divide step
    OP_TICK_FIX,   // elapsed ticks and new mark from quotient and remainder
    OP_CMP_TICK,   // compare = mark + one OS tick
    OP_MUL,        // clamp idle request, multiply by counts per tick
    OP_CMP_IDLE,   // compare = mark + product
    OP_GUARD,      // test compare against guard, load divider if too close
    OP_PUSH,       // push compare forward in whole OS ticks
    OP_EMIT        // hand result to the output register
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,    // pc + 1
    C_ALWAYS,  // target
    C_WAIT,    // advance on accept, else hold
    C_DIV,     // hold until last divide step
    C_FUNC,    // target if idle item
    C_ZERO,    // target if idle request is zero
    C_GUARD,   // target if compare already beyond guard
    C_OUT      // hold while output is full, else target
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic func;
    logic req_zero;
    logic div_last;
    logic guard_ok;
    logic out_busy;
  } seq_flags_t;

  localparam logic [PC_W-1:0] A_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] A_IDLE  = 4'd6;
  localparam logic [PC_W-1:0] A_GUARD = 4'd8;
  localparam logic [PC_W-1:0] A_EMIT  = 4'd11;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: A_WAIT};
    case (pc)
      4'd0:  w = '{op: OP_WAIT,      cond: C_WAIT,   target: A_WAIT};
      4'd1:  w = '{op: OP_NOP,       cond: C_FUNC,   target: A_IDLE};
      4'd2:  w = '{op: OP_LOAD_DIFF, cond: C_NEXT,   target: A_WAIT};
      4'd3:  w = '{op: OP_DIV_STEP,  cond: C_DIV,    target: A_WAIT};
      4'd4:  w = '{op: OP_TICK_FIX,  cond: C_NEXT,   target: A_WAIT};
      4'd5:  w = '{op: OP_CMP_TICK,  cond: C_ALWAYS, target: A_GUARD};
      4'd6:  w = '{op: OP_MUL,       cond: C_ZERO,   target: A_EMIT};
      4'd7:  w = '{op: OP_CMP_IDLE,  cond: C_NEXT,   target: A_WAIT};
      4'd8:  w = '{op: OP_GUARD,     cond: C_GUARD,  target: A_EMIT};
      4'd9:  w = '{op: OP_DIV_STEP,  cond: C_DIV,    target: A_WAIT};
      4'd10: w = '{op: OP_PUSH,      cond: C_NEXT,   target: A_WAIT};
      4'd11: w = '{op: OP_EMIT,      cond: C_OUT,    target: A_WAIT};
      default: w = '{op: OP_NOP, cond: C_ALWAYS, target: A_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/totc_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on totc_pkg.
`timescale 1ns / 1ps

module totc_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  totc_pkg::seq_flags_t  flags_i,
  output totc_pkg::uword_t      ctrl_o
);
  import totc_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          w;

  assign w      = ucode(pc_q);
  assign ctrl_o = w;

  always_comb begin
    pc_d = pc_q + 1'b1;
    case (w.cond)
      C_NEXT:   pc_d = pc_q + 1'b1;
      C_ALWAYS: pc_d = w.target;
      C_WAIT:   pc_d = flags_i.accept ? pc_q + 1'b1 : pc_q;
      C_DIV:    pc_d = flags_i.div_last ? pc_q + 1'b1 : pc_q;
      C_FUNC:   pc_d = flags_i.func ? w.target : pc_q + 1'b1;
      C_ZERO:   pc_d = flags_i.req_zero ? w.target : pc_q + 1'b1;
      C_GUARD:  pc_d = flags_i.guard_ok ? w.target : pc_q + 1'b1;
      C_OUT:    pc_d = flags_i.out_busy ? pc_q : w.target;
      default:  pc_d = A_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= A_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/tickless_os_tick_compare_core.sv
// Tick compare core for a tickless OS: last-tick mark, serial divider, compare placement.
// Depends on totc_pkg and totc_seq.
//
//   channel  | signals                                        | flow
//   ---------+------------------------------------------------+---------------------
//   in       | in_valid_i/in_ready_o, func, counter, request  | valid/ready, one word
//   out      | out_valid_o/out_ready_i, elapsed, compare      | valid/ready, one word
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i                | write strobe, no wait
//
// One item at a time. A tick word runs through the restoring divider (one quotient bit a cycle),
// and through it once more when the compare must be pushed past the guard. An idle word with
// a zero request goes straight to the emit step; otherwise the request is clamped and
// multiplied, with the same push when the compare lands inside the guard.
// A result waits in the output register while the next word is taken; a full output
// register holds the sequencer at its emit step. Reset clears the mark and loads the
// register defaults.
`timescale 1ns / 1ps

module tickless_os_tick_compare_core #(
  parameter int unsigned COUNTER_BITS  = 24,
  parameter int unsigned COMPARE_GUARD = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [totc_pkg::OUT_W-1:0]      counter_now_i,
  input  logic [totc_pkg::REQ_W-1:0]      idle_os_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [totc_pkg::OUT_W-1:0] elapsed_os_ticks_o,
  output logic                            compare_valid_o,
  output logic [totc_pkg::OUT_W-1:0]      compare_value_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [totc_pkg::CFG_W-1:0]      cfg_data_i
);
  import totc_pkg::*;

  localparam int unsigned CW  = COUNTER_BITS;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned DCW = $clog2(DW);
  localparam int unsigned EW  = (CW > OUT_W) ? CW : OUT_W;

  uword_t     ctrl;
  seq_flags_t flags;

  logic [TPO_W-1:0]  tpo_reg_q;
  logic [MAXI_W-1:0] max_idle_q;
  logic [TPO_W-1:0]  tpo;

  logic [CW-1:0]    mark_q, mark_d;
  logic [CW-1:0]    cnt_q, cmp_q, cmp_d, prod_q;
  logic             func_q, neg_q, neg_d, cvalid_q;
  logic [REQ_W-1:0] req_q;
  logic [DW-1:0]    acc_q, acc_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DCW-1:0]   div_cnt_q;
  logic signed [CW-1:0] el_q, el_d;

  logic             out_valid_q;
  logic signed [OUT_W-1:0] out_el_q;
  logic             out_cv_q;
  logic [OUT_W-1:0] out_cmp_q;

  logic             accept, out_busy;
  logic [EW-1:0]    cnt_ext;
  logic [CW-1:0]    diff, mag, d2, rem_c, quo;
  logic [DW-1:0]    gap;
  logic             guard_ok;
  logic [REM_W-1:0] rem_sh;
  logic [DW-1:0]    acc_sh;
  logic [MAXI_W-1:0] clamp;
  logic [PROD_W-1:0] prod_full;
  logic signed [EW-1:0] el_ext;
  logic [EW-1:0]    cmp_ext;

  function automatic logic idle_os_ticks_check(input logic [REQ_W-1:0] r,
                                               input logic [MAXI_W-1:0] m);
    return r > REQ_W'(m);
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpo_reg_q  <= TPO_RESET;
      max_idle_q <= MAXI_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TPO:      tpo_reg_q  <= cfg_data_i[TPO_W-1:0];
        CFG_MAX_IDLE: max_idle_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // zero counts per tick behaves as one
  assign tpo = (tpo_reg_q == '0) ? TPO_W'(1) : tpo_reg_q;

  // ---------------- sequencer ----------------
  totc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign in_ready_o = (ctrl.op == OP_WAIT);
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;

  assign flags.accept   = accept;
  assign flags.func     = func_q;
  assign flags.req_zero = (req_q == '0);
  assign flags.div_last = (div_cnt_q == DCW'(DW - 1));
  assign flags.guard_ok = guard_ok;
  assign flags.out_busy = out_busy;

  // ---------------- datapath ----------------
  assign cnt_ext = EW'(counter_now_i);

  assign diff  = cnt_q - mark_q;
  assign mag   = diff[CW-1] ? (~diff + 1'b1) : diff;
  assign rem_c = CW'(rem_q[TPO_W-1:0]);
  assign quo   = acc_q[CW-1:0];

  assign d2       = cmp_q - cnt_q;
  assign guard_ok = $signed(d2) > $signed(CW'(COMPARE_GUARD));
  assign gap      = DW'(COMPARE_GUARD) - {d2[CW-1], d2};

  // restoring divide step: shift in next dividend bit, subtract if it fits
  assign rem_sh = {rem_q[REM_W-2:0], acc_q[DW-1]};
  assign acc_sh = {acc_q[DW-2:0], 1'b0};

  assign clamp     = (idle_os_ticks_check(req_q, max_idle_q)) ? max_idle_q
                                                              : req_q[MAXI_W-1:0];
  assign prod_full = PROD_W'(clamp) * PROD_W'(tpo);

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    el_d   = el_q;
    mark_d = mark_q;
    cmp_d  = cmp_q;
    case (ctrl.op)
      OP_LOAD_DIFF: begin
        acc_d = {1'b0, mag};
        rem_d = '0;
        neg_d = diff[CW-1];
      end
      OP_DIV_STEP: begin
        if (rem_sh >= REM_W'(tpo)) begin
          rem_d = rem_sh - REM_W'(tpo);
          acc_d = acc_sh | DW'(1);
        end else begin
          rem_d = rem_sh;
          acc_d = acc_sh;
        end
      end
      OP_TICK_FIX: begin
        // truncation toward zero: mark lands on counter minus the signed remainder
        el_d   = neg_q ? -$signed(quo) : $signed(quo);
        mark_d = neg_q ? cnt_q + rem_c : cnt_q - rem_c;
      end
      OP_CMP_TICK: cmp_d = mark_q + CW'(tpo);
      OP_CMP_IDLE: cmp_d = mark_q + prod_q;
      OP_GUARD: begin
        acc_d = gap;
        rem_d = '0;
      end
      OP_PUSH: cmp_d = cnt_q + CW'(COMPARE_GUARD) + CW'(tpo) - rem_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else begin
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cmp_q <= cmp_d;
    if (ctrl.op == OP_MUL) begin
      prod_q <= prod_full[CW-1:0];
    end
    if (ctrl.op == OP_LOAD_DIFF || ctrl.op == OP_GUARD) begin
      div_cnt_q <= '0;
    end else if (ctrl.op == OP_DIV_STEP) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (accept) begin
      func_q   <= func_i;
      cnt_q    <= cnt_ext[CW-1:0];
      req_q    <= idle_os_ticks_i;
      el_q     <= '0;
      cvalid_q <= !(func_i && (idle_os_ticks_i == '0));
    end else begin
      el_q <= el_d;
    end
  end

  // ---------------- output register ----------------
  assign el_ext  = EW'(el_q);
  assign cmp_ext = EW'(cmp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      out_el_q  <= el_ext[OUT_W-1:0];
      out_cv_q  <= cvalid_q;
      out_cmp_q <= cvalid_q ? cmp_ext[OUT_W-1:0] : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign elapsed_os_ticks_o = out_el_q;
  assign compare_valid_o    = out_cv_q;
  assign compare_value_o    = out_cmp_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken again right after accept");

  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.op == OP_EMIT))
    else $error("result shown outside the emit step");

  a_no_compare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !compare_valid_o) |-> (compare_value_o == '0 && elapsed_os_ticks_o == '0))
    else $error("unprogrammed compare carries data");
`endif

endmodule

// File: tb/tickless_os_tick_compare_core_tb.sv
// Self-checking testbench for tickless_os_tick_compare_core: directed table, then random phases.
// Depends on totc_pkg and the core RTL; its own tick/compare model predicts each untyped result word.
`timescale 1ns / 1ps

module tickless_os_tick_compare_core_tb;
  import totc_pkg::*;

  localparam int  CNT_W      = OUT_W;
  localparam longint GUARD   = 2;
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_IDLE = 1'b1;
  localparam int  N_PHASES   = 8;
  localparam int  WORDS_PER_PHASE = 232;
  localparam int  STALL_PHASE  = 1;
  localparam int  RANDOM_PHASE = 6;
  localparam int  SETTLE_CYCLES = 64;
  localparam int  LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [CNT_W-1:0] elapsed;
    logic                    cmp_valid;
    logic [CNT_W-1:0]        cmp_value;
  } tick_result_t;

  typedef struct packed {
    logic             func;
    logic [CNT_W-1:0] counter;
    logic [REQ_W-1:0] req;
    logic             known;
    tick_result_t     want;
  } dir_row_t;

  localparam tick_result_t NONE = '{24'sd0, 1'b0, 24'd0};

  // Expected words are typed only where they can be read off directly.
  localparam dir_row_t DIRECTED [19] = '{
    '{FUNC_TICK, 24'd0,        32'd0,        1'b1, '{24'sd0,     1'b1, 24'd256}},
    '{FUNC_IDLE, 24'd0,        32'd0,        1'b1, NONE},
    '{FUNC_TICK, 24'd2560,     32'hFFFFFFFF, 1'b1, '{24'sd10,    1'b1, 24'd2816}},
    '{FUNC_TICK, 24'd2815,     32'd0,        1'b0, NONE},
    '{FUNC_TICK, 24'd2559,     32'd0,        1'b1, '{24'sd0,     1'b1, 24'd2816}},
    '{FUNC_TICK, 24'd2047,     32'd0,        1'b0, NONE},
    '{FUNC_IDLE, 24'd2048,     32'd1,        1'b1, '{24'sd0,     1'b1, 24'd2304}},
    '{FUNC_IDLE, 24'd2048,     32'hFFFFFFFF, 1'b1, '{24'sd0,     1'b1, 24'd4196352}},
    '{FUNC_IDLE, 24'd2048,     32'd16385,    1'b1, '{24'sd0,     1'b1, 24'd4196352}},
    '{FUNC_TICK, 24'hFFFFFF,   32'd0,        1'b1, '{24'hFFFFF8, 1'b1, 24'd256}},
    '{FUNC_TICK, 24'h7FFFFF,   32'd0,        1'b1, '{24'sd32767, 1'b1, 24'h800100}},
    '{FUNC_TICK, 24'hFFFF00,   32'd0,        1'b1, '{24'hFF8000, 1'b1, 24'd0}},
    '{FUNC_IDLE, 24'd44,       32'd1,        1'b0, NONE},
    '{FUNC_TICK, 24'd0,        32'd0,        1'b0, NONE},
    '{FUNC_TICK, 24'd254,      32'd0,        1'b0, NONE},
    '{FUNC_TICK, 24'd253,      32'd0,        1'b0, NONE},
    '{FUNC_IDLE, 24'hABCDEF,   32'd0,        1'b1, NONE},
    '{FUNC_IDLE, 24'd0,        32'd16384,    1'b1, '{24'sd0,     1'b1, 24'h400000}},
    '{FUNC_IDLE, 24'd0,        32'd16385,    1'b1, '{24'sd0,     1'b1, 24'h400000}}
  };

  localparam logic [CFG_W-1:0] PHASE_TPO  [N_PHASES] = '{
    23'd1, 23'd32768, 23'd0, 23'h7FFFFF, 23'd3, 23'd100, 23'd256, 23'd256};
  localparam logic [CFG_W-1:0] PHASE_MAXI [N_PHASES] = '{
    23'd1, 23'd4194304, 23'd0, 23'h7FFFFF, 23'd5, 23'd100, 23'd16384, 23'd16384};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    func_i;
  logic [CNT_W-1:0]        counter_now_i;
  logic [REQ_W-1:0]        idle_os_ticks_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [CNT_W-1:0] elapsed_os_ticks_o;
  logic                    compare_valid_o;
  logic [CNT_W-1:0]        compare_value_o;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;

  tickless_os_tick_compare_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .counter_now_i      (counter_now_i),
    .idle_os_ticks_i    (idle_os_ticks_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .elapsed_os_ticks_o (elapsed_os_ticks_o),
    .compare_valid_o    (compare_valid_o),
    .compare_value_o    (compare_value_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Shadow of the block state and registers
  logic [CNT_W-1:0]  mark_q;
  logic [TPO_W-1:0]  tpo_q;
  logic [MAXI_W-1:0] maxi_q;

  tick_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  bit           quiet_tail;
  bit           long_hold_req;
  int unsigned  hold_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned eff_div();
    return (tpo_q == '0) ? 64'd1 : longint'(tpo_q);
  endfunction

  // signed distance a - b on the counter circle
  function automatic longint counter_delta(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W-1:0] r;
    r = a - b;
    return longint'($signed(r));
  endfunction

  function automatic logic [CNT_W-1:0] place_past_guard(logic [CNT_W-1:0] cmp,
                                                        logic [CNT_W-1:0] cnt);
    longint            d;
    longint unsigned   steps;
    longint unsigned   s;
    d = counter_delta(cmp, cnt);
    if (d > GUARD) return cmp;
    steps = longint'(GUARD - d) / eff_div() + 1;
    s = longint'(cmp) + steps * eff_div();
    return s[CNT_W-1:0];
  endfunction

  // Work out the result word of one accepted word and advance the mark.
  function automatic tick_result_t forecast_result(logic f, logic [CNT_W-1:0] cnt,
                                                   logic [REQ_W-1:0] req);
    tick_result_t    r;
    longint          d;
    longint          n;
    longint          moved;
    longint unsigned reach;
    logic [REQ_W-1:0] span;
    r = NONE;
    if (f == FUNC_TICK) begin
      d = counter_delta(cnt, mark_q);
      n = d / longint'(eff_div());
      moved = n * longint'(eff_div());
      mark_q = mark_q + moved[CNT_W-1:0];
      r.elapsed   = n[CNT_W-1:0];
      r.cmp_valid = 1'b1;
      r.cmp_value = place_past_guard(mark_q + CNT_W'(eff_div()), cnt);
    end else if (req != '0) begin
      span  = (req > REQ_W'(maxi_q)) ? REQ_W'(maxi_q) : req;
      reach = longint'(span) * eff_div();
      r.cmp_valid = 1'b1;
      r.cmp_value = place_past_guard(mark_q + reach[CNT_W-1:0], cnt);
    end
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on word %0d, %s: expected %h got %h", results_seen, field, want, got);
  endtask

  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", 32'd0, {8'd0, compare_value_o});
      end else begin
        want = pending_results.pop_front();
        if (elapsed_os_ticks_o !== want.elapsed)
          note_mismatch("elapsed_os_ticks", {8'd0, want.elapsed}, {8'd0, elapsed_os_ticks_o});
        if (compare_valid_o !== want.cmp_valid)
          note_mismatch("compare_valid", {31'd0, want.cmp_valid}, {31'd0, compare_valid_o});
        if (compare_value_o !== want.cmp_value)
          note_mismatch("compare_value", {8'd0, want.cmp_value}, {8'd0, compare_value_o});
      end
      results_seen++;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the tail.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic f, input logic [CNT_W-1:0] cnt,
                           input logic [REQ_W-1:0] req, input logic typed,
                           input tick_result_t typed_res);
    int unsigned  gap;
    tick_result_t res;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    counter_now_i   <= cnt;
    idle_os_ticks_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    res = forecast_result(f, cnt, req);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Mostly counters near whole OS ticks from the mark, so quotients stay small
  // and the guard push fires; the rest spans the whole counter range.
  task automatic draw_word(output logic f, output logic [CNT_W-1:0] cnt,
                           output logic [REQ_W-1:0] req);
    longint           k;
    longint           off;
    longint           t;
    logic [REQ_W-1:0] span;
    f   = ($urandom_range(0, 9) < 6) ? FUNC_TICK : FUNC_IDLE;
    req = $urandom();
    case ($urandom_range(0, 4))
      0: req = '0;
      1: req = $urandom_range(1, 8);
      2: req = REQ_W'(maxi_q) + $urandom_range(0, 3) - 1;
      default: ;
    endcase
    k   = longint'($urandom_range(0, 12)) - 4;
    off = longint'($urandom_range(0, 6)) - 3;
    t   = longint'($urandom());
    if (f == FUNC_TICK) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: t = longint'(mark_q) + k * longint'(eff_div()) + off;
        6, 7: t = longint'(mark_q) + k * longint'(eff_div())
                  + longint'($urandom_range(0, 65535)) % longint'(eff_div());
        default: ;
      endcase
    end else begin
      span = (req > REQ_W'(maxi_q)) ? REQ_W'(maxi_q) : req;
      if ($urandom_range(0, 9) < 5)
        t = longint'(mark_q) + longint'(span) * longint'(eff_div()) - off - 3;
      else if ($urandom_range(0, 1) == 0)
        t = longint'(mark_q) + off;
    end
    cnt = t[CNT_W-1:0];
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TPO) tpo_q = data[TPO_W-1:0];
    else maxi_q = data[MAXI_W-1:0];
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every result word, then let the core settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic              f;
    logic [CNT_W-1:0]  cnt;
    logic [REQ_W-1:0]  req;
    logic [CFG_W-1:0]  tpo_val;
    logic [CFG_W-1:0]  maxi_val;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    func_i          = FUNC_TICK;
    counter_now_i   = '0;
    idle_os_ticks_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_TPO;
    cfg_data_i      = '0;
    mark_q          = '0;
    tpo_q           = TPO_RESET;
    maxi_q          = MAXI_RESET;
    mismatches      = 0;
    results_seen    = 0;
    quiet_tail      = 1'b0;
    long_hold_req   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      send_word(DIRECTED[i].func, DIRECTED[i].counter, DIRECTED[i].req,
                DIRECTED[i].known, DIRECTED[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      tpo_val  = PHASE_TPO[p];
      maxi_val = PHASE_MAXI[p];
      if (p == RANDOM_PHASE) begin
        tpo_val  = CFG_W'($urandom_range(1, 32768));
        maxi_val = CFG_W'($urandom_range(1, 4194304));
      end
      write_reg(CFG_TPO, tpo_val);
      write_reg(CFG_MAX_IDLE, maxi_val);
      if (p == STALL_PHASE) long_hold_req = 1'b1;
      if (p == N_PHASES - 1) quiet_tail = 1'b1;
      repeat (WORDS_PER_PHASE) begin
        draw_word(f, cnt, req);
        send_word(f, cnt, req, 1'b0, NONE);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
